// File: rtl/rpv_pkg.sv
// Package: widths, constants, codes and shared types of the rebalanced portfolio value block.
`timescale 1ns / 1ps
`default_nettype none

package rpv_pkg;

   // Asset lanes in hardware; the word carries FIELD_ASSETS return fields.
   localparam int N_ASSETS     = 4;
   localparam int FIELD_ASSETS = 4;
   localparam int LANES        = (N_ASSETS < FIELD_ASSETS) ? N_ASSETS : FIELD_ASSETS;
   localparam int IDX_W        = $clog2(LANES);
   localparam int CNT_W        = $clog2(LANES + 1);
   localparam int FIELD_IDX_W  = $clog2(FIELD_ASSETS);

   localparam int VAL_W      = 48;
   localparam int RET_W      = 32;
   localparam int WGT_W      = 32;
   localparam int TERM_W     = 16;
   localparam int COUNT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ACC_W      = VAL_W + MUL_W;
   localparam int FACTOR_W   = RET_W + 2;

   localparam logic [VAL_W-1:0] VMAX = {VAL_W{1'b1}};

   // Growth is round(h * n / (100 * 2^16)): add half, drop 16 bits, divide by 100.
   localparam logic [FACTOR_W-1:0] HUNDRED_Q16 = FACTOR_W'(6553600);
   localparam logic [ACC_W-1:0]    GROW_RND    = ACC_W'(3276800);
   localparam int                  GROW_SHIFT  = 16;
   // Rebalance is round(t * w / 2^30).
   localparam logic [ACC_W-1:0]    REB_RND     = ACC_W'(64'd1 << 29);
   localparam int                  REB_SHIFT   = 30;

   // Divide by 100, one 16-bit digit per step: q = (x * RECIP_100) >> RECIP_SHIFT
   // is exact for x < 100 * 2^16.
   localparam int                  DIG_BITS    = 16;
   localparam int                  DIGITS      = (ACC_W - GROW_SHIFT) / DIG_BITS;
   localparam int                  DIG_W       = $clog2(DIGITS);
   localparam int                  REM_W       = 7;
   localparam int                  X_W         = REM_W + DIG_BITS;
   localparam logic [MUL_W-1:0]    RECIP_100   = MUL_W'(10737419);
   localparam int                  RECIP_SHIFT = 30;
   localparam int                  QUO_W       = DIGITS * DIG_BITS;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT    = 3'd5;

   localparam logic [WGT_W-1:0]   WEIGHT_0_RST = 32'h4000_0000;
   localparam logic [COUNT_W-1:0] COUNT_RST    = 3'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GROW_LO,
      ST_GROW_HI,
      ST_DIV,
      ST_GROW_WB,
      ST_REB_LO,
      ST_REB_HI,
      ST_REB_WB,
      ST_PHASE,
      ST_PHASE_WAIT,
      ST_DONE
   } rpv_state_type;

   typedef enum logic [1:0] {
      MAC_NONE,
      MAC_LO,
      MAC_HI,
      MAC_DIV
   } rpv_mac_op_type;

   // Sequencer to datapath.
   typedef struct packed {
      logic                 req_ready;
      logic                 accept;
      rpv_mac_op_type       mac_op;
      logic                 reb_sel;
      logic [DIG_W-1:0]     digit_idx;
      logic [IDX_W-1:0]     asset_idx;
      logic                 wr_zero;
      logic                 wr_grow;
      logic                 wr_reb;
      logic                 phase_adv;
      logic                 rsp_load;
   } rpv_ctl_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic                 req_valid;
      logic                 slot_free;
      logic [CNT_W-1:0]     n_active;
      logic                 factor_pos;
      logic                 reb_now;
      logic                 phase_busy;
   } rpv_sts_type;

endpackage

`default_nettype wire

// File: rtl/rpv_req_if.sv
// Interface: input channel, one period word per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface rpv_req_if import rpv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    start_req;
   logic signed [RET_W-1:0] return_0;
   logic signed [RET_W-1:0] return_1;
   logic signed [RET_W-1:0] return_2;
   logic signed [RET_W-1:0] return_3;

   modport source (output valid, start_req, return_0, return_1, return_2, return_3,
                   input ready);
   modport sink   (input valid, start_req, return_0, return_1, return_2, return_3,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/rpv_rsp_if.sv
// Interface: result channel, one portfolio value word per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface rpv_rsp_if import rpv_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] portfolio_value;
   logic             saturated;

   modport source (output valid, portfolio_value, saturated, input ready);
   modport sink   (input valid, portfolio_value, saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/rpv_mac_unit.sv
// Shared 32x32 multiplier with accumulator and divide-by-100 digit stepper.
`timescale 1ns / 1ps
`default_nettype none

module rpv_mac_unit import rpv_pkg::*; (
   input  wire logic              clock,
   input  wire rpv_ctl_type       ctl,
   input  wire logic [VAL_W-1:0]  mcand,
   input  wire logic [MUL_W-1:0]  mplier,
   output logic      [VAL_W-1:0]  grow_val,
   output logic                   grow_sat,
   output logic      [VAL_W-1:0]  reb_val,
   output logic                   reb_sat
);

   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;

   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0]   prod;
   logic [DIG_BITS-1:0] digit;
   logic [X_W-1:0]      div_x;
   logic [DIG_BITS-1:0] q_dig;
   logic [X_W-1:0]      q_x100;
   logic [X_W-1:0]      div_diff;

   // Current dividend digit, most significant first
   assign digit = acc_ff[GROW_SHIFT + DIG_BITS * ctl.digit_idx +: DIG_BITS];
   assign div_x = {rem_ff, digit};

   always_comb begin
      case (ctl.mac_op)
         MAC_HI: begin
            mul_a = MUL_W'(mcand[VAL_W-1:MUL_W]);
            mul_b = mplier;
         end
         MAC_DIV: begin
            mul_a = MUL_W'(div_x);
            mul_b = RECIP_100;
         end
         default: begin
            mul_a = mcand[MUL_W-1:0];
            mul_b = mplier;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Quotient digit and remainder; x100 as shifts and adds
   assign q_dig    = prod[RECIP_SHIFT +: DIG_BITS];
   assign q_x100   = X_W'({q_dig, 6'b0}) + X_W'({q_dig, 5'b0}) + X_W'({q_dig, 2'b0});
   assign div_diff = div_x - q_x100;

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      case (ctl.mac_op)
         MAC_LO: begin
            acc_in = ACC_W'(prod) + (ctl.reb_sel ? REB_RND : GROW_RND);
         end
         MAC_HI: begin
            acc_in = acc_ff + {prod[VAL_W-1:0], {MUL_W{1'b0}}};
            rem_in = '0;
         end
         MAC_DIV: begin
            rem_in = div_diff[REM_W-1:0];
            quo_in = {quo_ff[QUO_W-DIG_BITS-1:0], q_dig};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign grow_sat = |quo_ff[QUO_W-1:VAL_W];
   assign grow_val = grow_sat ? VMAX : quo_ff[VAL_W-1:0];
   assign reb_sat  = |acc_ff[ACC_W-1:REB_SHIFT+VAL_W];
   assign reb_val  = reb_sat ? VMAX : acc_ff[REB_SHIFT +: VAL_W];

endmodule

`default_nettype wire

// File: rtl/rpv_phase_ctr.sv
// Period phase counter with a bit-serial modulo for a lowered term.
`timescale 1ns / 1ps
`default_nettype none

module rpv_phase_ctr import rpv_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              advance,
   input  wire logic [TERM_W-1:0] term,
   output logic      [TERM_W-1:0] phase,
   output logic                   busy
);

   localparam int NUM_W = TERM_W + 1;
   localparam int CNT_B = $clog2(NUM_W);

   logic [TERM_W-1:0] phase_ff, phase_in;
   logic              busy_ff, busy_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [TERM_W-1:0] rem_ff, rem_in;
   logic [CNT_B-1:0]  cnt_ff, cnt_in;

   logic [NUM_W-1:0]  inc;
   logic              fast;
   logic [NUM_W-1:0]  trial;
   logic [NUM_W-1:0]  trial_sub;

   assign inc   = {1'b0, phase_ff} + NUM_W'(1);
   assign fast  = (term == '0) || (inc <= {1'b0, term});
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign trial_sub = (trial >= {1'b0, term}) ? (trial - {1'b0, term}) : trial;

   always_comb begin
      phase_in = phase_ff;
      busy_in  = busy_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (clear) begin
         phase_in = '0;
      end else if (busy_ff) begin
         rem_in = trial_sub[TERM_W-1:0];
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            phase_in = trial_sub[TERM_W-1:0];
            busy_in  = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_B'(1);
         end
      end else if (advance) begin
         if (fast) begin
            // term zero or wrap at term: back to zero
            phase_in = ((term == '0) || (inc == {1'b0, term})) ? '0 : inc[TERM_W-1:0];
         end else begin
            busy_in = 1'b1;
            num_in  = inc;
            rem_in  = '0;
            cnt_in  = CNT_B'(NUM_W - 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign phase = phase_ff;
   assign busy  = busy_ff;

endmodule

`default_nettype wire

// File: rtl/rpv_ctrl.sv
// Sequencer: walks assets through growth, summation and rebalance steps.
`timescale 1ns / 1ps
`default_nettype none

module rpv_ctrl import rpv_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rpv_sts_type sts,
   output rpv_ctl_type      ctl
);

   localparam logic [DIG_W-1:0] LAST_DIGIT = DIG_W'(DIGITS - 1);

   rpv_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  asset_ff, asset_in;
   logic [DIG_W-1:0]  digit_ff, digit_in;
   logic              reb_ff, reb_in;
   logic              last_asset;

   assign last_asset = (CNT_W'(asset_ff) + CNT_W'(1)) == sts.n_active;

   // Next state
   always_comb begin
      state_in = state_ff;
      asset_in = asset_ff;
      digit_in = digit_ff;
      reb_in   = reb_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sts.req_valid) begin
               state_in = ST_GROW_LO;
               asset_in = '0;
               reb_in   = sts.reb_now;
            end
         end
         ST_GROW_LO: begin
            if (!sts.factor_pos) begin
               if (last_asset) begin
                  asset_in = '0;
                  state_in = reb_ff ? ST_REB_LO : ST_PHASE;
               end else begin
                  asset_in = asset_ff + IDX_W'(1);
               end
            end else begin
               state_in = ST_GROW_HI;
            end
         end
         ST_GROW_HI: begin
            state_in = ST_DIV;
            digit_in = LAST_DIGIT;
         end
         ST_DIV: begin
            if (digit_ff == '0) begin
               state_in = ST_GROW_WB;
            end else begin
               digit_in = digit_ff - DIG_W'(1);
            end
         end
         ST_GROW_WB: begin
            if (last_asset) begin
               asset_in = '0;
               state_in = reb_ff ? ST_REB_LO : ST_PHASE;
            end else begin
               asset_in = asset_ff + IDX_W'(1);
               state_in = ST_GROW_LO;
            end
         end
         ST_REB_LO: begin
            state_in = ST_REB_HI;
         end
         ST_REB_HI: begin
            state_in = ST_REB_WB;
         end
         ST_REB_WB: begin
            if (last_asset) begin
               state_in = ST_PHASE;
            end else begin
               asset_in = asset_ff + IDX_W'(1);
               state_in = ST_REB_LO;
            end
         end
         ST_PHASE: begin
            state_in = ST_PHASE_WAIT;
         end
         ST_PHASE_WAIT: begin
            if (!sts.phase_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      ctl           = '0;
      ctl.mac_op    = MAC_NONE;
      ctl.asset_idx = asset_ff;
      ctl.digit_idx = digit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = 1'b1;
            ctl.accept    = sts.req_valid;
         end
         ST_GROW_LO: begin
            ctl.mac_op  = sts.factor_pos ? MAC_LO : MAC_NONE;
            ctl.wr_zero = !sts.factor_pos;
         end
         ST_GROW_HI: begin
            ctl.mac_op = MAC_HI;
         end
         ST_DIV: begin
            ctl.mac_op = MAC_DIV;
         end
         ST_GROW_WB: begin
            ctl.wr_grow = 1'b1;
         end
         ST_REB_LO: begin
            ctl.mac_op  = MAC_LO;
            ctl.reb_sel = 1'b1;
         end
         ST_REB_HI: begin
            ctl.mac_op  = MAC_HI;
            ctl.reb_sel = 1'b1;
         end
         ST_REB_WB: begin
            ctl.reb_sel = 1'b1;
            ctl.wr_reb  = 1'b1;
         end
         ST_PHASE: begin
            ctl.phase_adv = 1'b1;
         end
         ST_PHASE_WAIT: begin
         end
         ST_DONE: begin
            ctl.rsp_load = sts.slot_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         asset_ff <= '0;
         digit_ff <= '0;
         reb_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         asset_ff <= asset_in;
         digit_ff <= digit_in;
         reb_ff   <= reb_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/rebalanced_portfolio_value.sv
// Top level: rebalanced portfolio value, one period word in, one value word out.
`timescale 1ns / 1ps
`default_nettype none

// Tracks one holding per asset (unsigned Q16.32, 48 bits) and returns the
// portfolio value after each period word. A word with start_req set (and the
// first word after reset) reloads holdings from the weight registers
// (weight << 2) and clears the period phase. Each active holding then grows by
// (1 + return/100), rounded half up; a return at or below -100 percent zeroes
// it without a flag. The sum of the holdings is the result. When the
// rebalance term is nonzero and the phase was zero, every active holding is
// then reset to round(total * weight / 2^30). Any value clipped at 2^48-1
// raises saturated. All arithmetic runs on one shared 32x32 multiplier under
// a small sequencer: a growth runs two multiply-accumulate steps, four
// divide-by-100 digit steps and one write back and sum per asset, or only a
// zeroing step for a zeroed asset; a rebalance runs two multiply-accumulate
// steps and one write back per asset. Right after the term is lowered to or
// below the phase, the phase wrap runs a bit-serial modulo while the
// sequencer waits. The block is not ready while a word is in flight; a finished
// value waits in the output register, and the next word is accepted meanwhile.
// Configuration writes take effect at once and belong in idle time.

module rebalanced_portfolio_value import rpv_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rpv_req_if.sink                    req_chan,
   rpv_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   // ---- configuration registers
   logic [WGT_W-1:0]   weight_ff [FIELD_ASSETS];
   logic [WGT_W-1:0]   weight_in [FIELD_ASSETS];
   logic [TERM_W-1:0]  term_ff, term_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // ---- block state
   logic               primed_ff, primed_in;
   logic [VAL_W-1:0]   holding_ff [LANES];
   logic [VAL_W-1:0]   holding_in [LANES];
   logic [RET_W-1:0]   ret_ff [LANES];
   logic [RET_W-1:0]   ret_in [LANES];
   logic [VAL_W-1:0]   total_ff, total_in;
   logic               sat_ff, sat_in;

   // ---- output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic               rsp_sat_ff, rsp_sat_in;

   rpv_ctl_type        ctl;
   rpv_sts_type        sts;

   logic [RET_W-1:0]    field_ret [FIELD_ASSETS];
   logic [WGT_W-1:0]    wgt_lane [LANES];
   logic [COUNT_W-1:0]  n_act3;
   logic                load;
   logic [TERM_W-1:0]   phase;
   logic                phase_busy;
   logic [RET_W-1:0]    cur_ret;
   logic [FACTOR_W-1:0] factor;
   logic [VAL_W-1:0]    mcand;
   logic [MUL_W-1:0]    mplier;
   logic [VAL_W-1:0]    grow_val, reb_val;
   logic                grow_sat, reb_sat;
   logic [VAL_W:0]      sum;

   assign field_ret[0] = req_chan.return_0;
   assign field_ret[1] = req_chan.return_1;
   assign field_ret[2] = req_chan.return_2;
   assign field_ret[3] = req_chan.return_3;

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      assign wgt_lane[j] = weight_ff[j];
   end

   // Active asset count: zero acts as one, clamp at the lane count
   always_comb begin
      if (count_ff == '0) begin
         n_act3 = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(LANES)) begin
         n_act3 = COUNT_W'(LANES);
      end else begin
         n_act3 = count_ff;
      end
   end

   assign load = req_chan.start_req || !primed_ff;

   // Growth factor 6553600 + r; zero or negative wipes the holding
   assign cur_ret = ret_ff[ctl.asset_idx];
   assign factor  = {{2{cur_ret[RET_W-1]}}, cur_ret} + HUNDRED_Q16;

   assign mcand  = ctl.reb_sel ? total_ff : holding_ff[ctl.asset_idx];
   assign mplier = ctl.reb_sel ? wgt_lane[ctl.asset_idx] : factor[MUL_W-1:0];

   assign sum = {1'b0, total_ff} + {1'b0, grow_val};

   always_comb begin
      sts.req_valid  = req_chan.valid;
      sts.slot_free  = !rsp_valid_ff || rsp_chan.ready;
      sts.n_active   = n_act3[CNT_W-1:0];
      sts.factor_pos = !factor[FACTOR_W-1] && (factor != '0);
      sts.reb_now    = (term_ff != '0) && (load || (phase == '0));
      sts.phase_busy = phase_busy;
   end

   rpv_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   rpv_mac_unit u_mac (
      .clock    (clock),
      .ctl      (ctl),
      .mcand    (mcand),
      .mplier   (mplier),
      .grow_val (grow_val),
      .grow_sat (grow_sat),
      .reb_val  (reb_val),
      .reb_sat  (reb_sat)
   );

   rpv_phase_ctr u_phase (
      .clock   (clock),
      .reset   (reset),
      .clear   (ctl.accept && load),
      .advance (ctl.phase_adv),
      .term    (term_ff),
      .phase   (phase),
      .busy    (phase_busy)
   );

   // ---- configuration writes
   always_comb begin
      weight_in = weight_ff;
      term_in   = term_ff;
      count_in  = count_ff;
      if (csr_wr_en) begin
         unique case (csr_index) inside
            CSR_WEIGHT_0, CSR_WEIGHT_1, CSR_WEIGHT_2, CSR_WEIGHT_3: begin
               weight_in[csr_index[FIELD_IDX_W-1:0]] = csr_wr_data[WGT_W-1:0];
            end
            CSR_TERM: begin
               term_in = csr_wr_data[TERM_W-1:0];
            end
            CSR_COUNT: begin
               count_in = csr_wr_data[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < FIELD_ASSETS; j++) begin
            weight_ff[j] <= (j == 0) ? WEIGHT_0_RST : '0;
         end
         term_ff  <= '0;
         count_ff <= COUNT_RST;
      end else begin
         weight_ff <= weight_in;
         term_ff   <= term_in;
         count_ff  <= count_in;
      end
   end

   // ---- holdings, total and flag
   always_comb begin
      primed_in  = primed_ff;
      holding_in = holding_ff;
      ret_in     = ret_ff;
      total_in   = total_ff;
      sat_in     = sat_ff;
      if (ctl.accept) begin
         primed_in = 1'b1;
         total_in  = '0;
         sat_in    = 1'b0;
         for (int j = 0; j < LANES; j++) begin
            ret_in[j] = field_ret[j];
            // inactive lanes stay at zero; reload from weight on a start
            if (COUNT_W'(j) >= n_act3) begin
               holding_in[j] = '0;
            end else if (load) begin
               holding_in[j] = {{(VAL_W - WGT_W - 2){1'b0}}, weight_ff[j], 2'b00};
            end
         end
      end
      if (ctl.wr_zero) begin
         holding_in[ctl.asset_idx] = '0;
      end
      if (ctl.wr_grow) begin
         holding_in[ctl.asset_idx] = grow_val;
         total_in = sum[VAL_W] ? VMAX : sum[VAL_W-1:0];
         sat_in   = sat_ff | grow_sat | sum[VAL_W];
      end
      if (ctl.wr_reb) begin
         holding_in[ctl.asset_idx] = reb_val;
         sat_in = sat_ff | reb_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         for (int j = 0; j < LANES; j++) begin
            holding_ff[j] <= '0;
         end
      end else begin
         primed_ff  <= primed_in;
         holding_ff <= holding_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      total_ff <= total_in;
      sat_ff   <= sat_in;
   end

   // ---- result register: holds a word until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = total_ff;
         rsp_sat_in   = sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_chan.ready           = ctl.req_ready;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.portfolio_value = rsp_value_ff;
   assign rsp_chan.saturated       = rsp_sat_ff;

endmodule

`default_nettype wire

// File: dv/tb_rebalanced_portfolio_value.sv
// Testbench: rebalanced portfolio value, directed table then random periods, self-checking.
`timescale 1ns / 1ps

module tb_rebalanced_portfolio_value import rpv_pkg::*; ();

   // ---------------------------------------------------------------------------------------
   // Run shape
   // ---------------------------------------------------------------------------------------
   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 6;
   localparam int RANDOM_PERIODS   = 1200;
   localparam int CALM_PERIODS     = 150;     // tail of the run with no idling at all
   localparam int PRESSURE_SEGMENT = 3;       // segment in which the receiver holds off
   localparam int HOLD_CYCLES      = 400;
   localparam int TAIL_CYCLES      = 80;      // > one word with rebalance and phase wrap
   localparam int CYCLE_LIMIT      = 600000;
   localparam int MAX_REPORTS      = 10;

   // Growth is round(h * (6553600 + r) / 6553600), i.e. h * (1 + r/100) in Q16.16 percent.
   localparam logic [95:0] GROWTH_DIV  = 96'd6553600;
   localparam logic [95:0] GROWTH_HALF = 96'd3276800;
   localparam logic [95:0] SCALE_HALF  = 96'd1 << 29;

   // Return field extremes (signed Q16.16 percent).
   localparam logic [RET_W-1:0] RET_MIN   = 32'hFF9C_0000;   // -100 %
   localparam logic [RET_W-1:0] RET_MAX   = 32'h7FFF_FFFF;
   localparam logic [RET_W-1:0] RET_UP100 = 32'h0064_0000;   // +100 %, doubles a holding
   localparam logic [RET_W-1:0] RET_DOWN  = 32'hFFFF_FFFF;   // smallest loss

   localparam logic [VAL_W-1:0] ONE_Q32 = 48'h0001_0000_0000;
   localparam logic [VAL_W-1:0] TWO_Q32 = 48'h0002_0000_0000;

   // Register presets used by the directed table.
   localparam int PS_NONE         = -1;
   localparam int PS_QUARTERS     = 0;
   localparam int PS_HEAVY        = 1;
   localparam int PS_EMPTY        = 2;
   localparam int PS_HALVES_LONG  = 3;
   localparam int PS_HALVES_SHORT = 4;
   localparam int PS_ODD          = 5;

   typedef struct packed {
      logic                                start;
      logic [FIELD_ASSETS-1:0][RET_W-1:0] ret;
   } period_word_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             sat;
   } value_word_type;

   typedef struct packed {
      logic [FIELD_ASSETS-1:0][WGT_W-1:0] w;
      logic [TERM_W-1:0]                  term;
      logic [COUNT_W-1:0]                 count;
   } csr_set_type;

   typedef struct {
      period_word_type word;
      int              preset;
      bit              typed;     // want holds a hand-derived value
      value_word_type  want;
   } script_row_type;

   // ---------------------------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   always #(CLK_PERIOD / 2) clock = ~clock;

   rpv_req_if req_chan ();
   rpv_rsp_if rsp_chan ();

   rebalanced_portfolio_value u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------------------------
   // Portfolio predictor: shadow registers and per-asset holdings
   // ---------------------------------------------------------------------------------------
   csr_set_type       csr_shadow;
   logic [VAL_W-1:0]  asset_value [FIELD_ASSETS];
   logic [TERM_W-1:0] phase_count;
   bit                loaded;

   value_word_type pending_values [$];   // expected value words, oldest first
   script_row_type script [$];
   csr_set_type    presets [6];

   int fault_count    = 0;
   int periods_sent   = 0;
   int values_checked = 0;
   int sat_seen       = 0;
   int starts_seen    = 0;
   int rebalances     = 0;
   int settings_used  = 0;
   int cycle_count    = 0;

   // Idling knobs, percent chance per opportunity.
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int hold_ask      = 0;   // bumped by stimulus; receiver starts a long hold on change

   // One period: optional reload, growth of each active asset, sum, rebalance, phase step.
   function automatic void advance_period(input period_word_type wd,
                                          output value_word_type res);
      int          n;
      logic [48:0] total;
      logic signed [33:0] num;
      logic [95:0] acc;
      logic [16:0] nxt;
      n = int'(csr_shadow.count);
      if (n == 0) n = 1;
      if (n > LANES) n = LANES;
      res.sat = 1'b0;
      total   = '0;

      if (wd.start || !loaded) begin
         for (int j = 0; j < FIELD_ASSETS; j++)
            asset_value[j] = (j < n) ? {14'b0, csr_shadow.w[j], 2'b00} : '0;
         phase_count = '0;
         loaded      = 1'b1;
         starts_seen++;
      end

      for (int j = 0; j < FIELD_ASSETS; j++) begin
         if (j < n) begin
            num = 34'sd6553600 + {{2{wd.ret[j][RET_W-1]}}, wd.ret[j]};
            if (num <= 0) begin
               asset_value[j] = '0;   // wiped out, no flag
            end else begin
               acc = (96'(asset_value[j]) * 96'(num[31:0]) + GROWTH_HALF) / GROWTH_DIV;
               if (acc > 96'(VMAX)) begin
                  res.sat        = 1'b1;
                  asset_value[j] = VMAX;
               end else begin
                  asset_value[j] = acc[VAL_W-1:0];
               end
            end
            total = total + 49'(asset_value[j]);
            if (total > 49'(VMAX)) begin
               res.sat = 1'b1;
               total   = 49'(VMAX);
            end
         end else begin
            asset_value[j] = '0;
         end
      end

      if (csr_shadow.term != 0 && phase_count == 0) begin
         rebalances++;
         for (int j = 0; j < n; j++) begin
            acc = (96'(total[VAL_W-1:0]) * 96'(csr_shadow.w[j]) + SCALE_HALF) >> 30;
            if (acc > 96'(VMAX)) begin
               res.sat        = 1'b1;
               asset_value[j] = VMAX;
            end else begin
               asset_value[j] = acc[VAL_W-1:0];
            end
         end
      end

      // A phase left above a lowered term just wraps; no rebalance on that period.
      if (csr_shadow.term != 0) begin
         nxt         = 17'(phase_count) + 17'd1;
         phase_count = TERM_W'(nxt % {1'b0, csr_shadow.term});
      end else begin
         phase_count = '0;
      end
      res.value = total[VAL_W-1:0];
   endfunction

   function automatic void log_fault(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("MISMATCH %s (value word %0d): expected 0x%012h, got 0x%012h",
                  what, values_checked, want, got);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result side: check every accepted word, drive ready with stalls and the long hold
   // ---------------------------------------------------------------------------------------
   int stall_left = 0;
   int hold_left  = 0;
   int hold_seen  = 0;

   always @(posedge clock) begin
      value_word_type got;
      value_word_type want;
      if (rsp_chan.valid && rsp_chan.ready) begin
         got.value = rsp_chan.portfolio_value;
         got.sat   = rsp_chan.saturated;
         if (got.sat) sat_seen++;
         if (pending_values.size() == 0) begin
            log_fault("word with nothing expected", '0, got.value);
         end else begin
            want = pending_values.pop_front();
            if (got.value !== want.value) log_fault("portfolio_value", want.value, got.value);
            if (got.sat !== want.sat)
               log_fault("saturated", VAL_W'(want.sat), VAL_W'(got.sat));
         end
         values_checked++;
      end

      if (hold_seen != hold_ask) begin
         hold_seen = hold_ask;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
         stall_left = $urandom_range(0, 14);   // start a stall burst
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d value words outstanding",
                  cycle_count, pending_values.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic void row(bit start, logic [RET_W-1:0] r0, logic [RET_W-1:0] r1,
                               logic [RET_W-1:0] r2, logic [RET_W-1:0] r3, int preset,
                               bit typed, logic [VAL_W-1:0] value, bit sat);
      script_row_type e;
      e.word.start  = start;
      e.word.ret[0] = r0;
      e.word.ret[1] = r1;
      e.word.ret[2] = r2;
      e.word.ret[3] = r3;
      e.preset      = preset;
      e.typed       = typed;
      e.want.value  = value;
      e.want.sat    = sat;
      script.push_back(e);
   endfunction

   function automatic csr_set_type make_set(logic [WGT_W-1:0] w0, logic [WGT_W-1:0] w1,
                                            logic [WGT_W-1:0] w2, logic [WGT_W-1:0] w3,
                                            logic [TERM_W-1:0] term,
                                            logic [COUNT_W-1:0] count);
      csr_set_type s;
      s.w[0]  = w0;
      s.w[1]  = w1;
      s.w[2]  = w2;
      s.w[3]  = w3;
      s.term  = term;
      s.count = count;
      return s;
   endfunction

   // Mostly small moves so holdings stay in range; extremes now and then.
   function automatic logic [RET_W-1:0] draw_return();
      case ($urandom_range(0, 39))
         0:       return RET_MIN;
         1:       return RET_MAX;
         2:       return RET_W'($urandom_range(0, 32'h7FFF_FFFF));
         3, 4, 5: return 32'd0 - 32'($urandom_range(1, 6553600));
         default: return 32'($urandom_range(0, 1310720)) - 32'd655360;   // +/- 10 %
      endcase
   endfunction

   function automatic csr_set_type draw_settings();
      csr_set_type s;
      for (int j = 0; j < FIELD_ASSETS; j++) begin
         case ($urandom_range(0, 7))
            0:       s.w[j] = '0;
            1:       s.w[j] = '1;
            2:       s.w[j] = 32'h4000_0000;
            default: s.w[j] = WGT_W'($urandom_range(0, 32'h5000_0000));
         endcase
      end
      case ($urandom_range(0, 7))
         0:       s.term = '0;
         1:       s.term = 16'd1;
         2:       s.term = '1;
         3:       s.term = TERM_W'($urandom);
         default: s.term = TERM_W'($urandom_range(2, 9));
      endcase
      s.count = COUNT_W'($urandom_range(0, 7));
      return s;
   endfunction

   function automatic int draw_idle_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 5;
         2:       return 20;
         default: return 40;
      endcase
   endfunction

   // Offer one period word, hold it until taken, then predict and maybe go idle.
   task automatic offer_word(input period_word_type wd, input bit typed,
                             input value_word_type want);
      value_word_type predicted;
      req_chan.valid     <= 1'b1;
      req_chan.start_req <= wd.start;
      req_chan.return_0  <= wd.ret[0];
      req_chan.return_1  <= wd.ret[1];
      req_chan.return_2  <= wd.ret[2];
      req_chan.return_3  <= wd.ret[3];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      advance_period(wd, predicted);
      pending_values.push_back(typed ? want : predicted);
      periods_sent++;
      if (req_gap_pct != 0 && $urandom_range(1, 100) <= req_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Stop offering, let every value word come back and the sequencer go idle.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_values.size() != 0 || !req_chan.ready) @(posedge clock);
   endtask

   task automatic csr_poke(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // Only called with the block idle, so the shadow can switch at once.
   task automatic program_csr(input csr_set_type s);
      csr_poke(CSR_WEIGHT_0, s.w[0]);
      csr_poke(CSR_WEIGHT_1, s.w[1]);
      csr_poke(CSR_WEIGHT_2, s.w[2]);
      csr_poke(CSR_WEIGHT_3, s.w[3]);
      csr_poke(CSR_TERM, CSR_DATA_W'(s.term));
      csr_poke(CSR_COUNT, CSR_DATA_W'(s.count));
      csr_wr_en  <= 1'b0;
      csr_shadow = s;
      settings_used++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      period_word_type wd;
      int              len;
      int              seg;
      int              random_done;
      bit              first_start;

      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_WEIGHT_0;
      csr_wr_data        <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.start_req <= 1'b0;
      req_chan.return_0  <= '0;
      req_chan.return_1  <= '0;
      req_chan.return_2  <= '0;
      req_chan.return_3  <= '0;

      // Predictor state after reset: asset 0 at full weight, one asset, no rebalance.
      csr_shadow = make_set(WEIGHT_0_RST, '0, '0, '0, '0, COUNT_RST);
      for (int j = 0; j < FIELD_ASSETS; j++) asset_value[j] = '0;
      phase_count = '0;
      loaded      = 1'b0;

      presets[PS_QUARTERS]     = make_set(32'h1000_0000, 32'h1000_0000, 32'h1000_0000,
                                          32'h1000_0000, 16'd1, 3'd4);
      presets[PS_HEAVY]        = make_set('1, '1, '1, '1, 16'd3, 3'd7);   // count above 4
      presets[PS_EMPTY]        = make_set('0, '0, '0, '0, '1, 3'd0);      // count 0 acts as 1
      presets[PS_HALVES_LONG]  = make_set(32'h2000_0000, 32'h2000_0000, '0, '0, 16'd5, 3'd2);
      presets[PS_HALVES_SHORT] = make_set(32'h2000_0000, 32'h2000_0000, '0, '0, 16'd2, 3'd2);
      presets[PS_ODD]          = make_set(32'h0000_0001, 32'h3FFF_FFFF, 32'h8000_0000,
                                          32'h0000_FFFF, 16'd2, 3'd5);

      // Directed table. Hand values: reset weight 1.0 loads 2^32; +100 % doubles;
      // -100 % wipes out; max returns twice in a row clip every holding.
      row(1'b0, '0, '0, '0, '0, PS_NONE, 1'b1, ONE_Q32, 1'b0);       // first word loads
      row(1'b0, RET_UP100, '0, '0, '0, PS_NONE, 1'b1, TWO_Q32, 1'b0);
      row(1'b0, RET_MIN, RET_MAX, RET_MAX, RET_MAX, PS_NONE, 1'b1, '0, 1'b0);  // idle lanes
      row(1'b1, '0, RET_MIN, '0, '0, PS_NONE, 1'b1, ONE_Q32, 1'b0);
      row(1'b0, RET_MAX, '0, '0, '0, PS_NONE, 1'b0, '0, 1'b0);
      row(1'b0, RET_MAX, '0, '0, '0, PS_NONE, 1'b1, VMAX, 1'b1);
      row(1'b0, RET_DOWN, '0, '0, '0, PS_NONE, 1'b0, '0, 1'b0);
      // Quarters with a rebalance every period; the first two words total 1.0.
      row(1'b1, '0, '0, '0, '0, PS_QUARTERS, 1'b1, ONE_Q32, 1'b0);
      row(1'b0, RET_UP100, '0, '0, RET_MIN, PS_NONE, 1'b1, ONE_Q32, 1'b0);
      row(1'b0, 32'h0001_8000, 32'hFFFE_0000, 32'h0123_4567, RET_DOWN, PS_NONE, 1'b0, '0, 1'b0);
      // Max weights: rebalance grows the book about sixteenfold, next max period clips.
      row(1'b1, RET_MAX, RET_MAX, RET_MAX, RET_MAX, PS_HEAVY, 1'b0, '0, 1'b0);
      row(1'b0, RET_MAX, RET_MAX, RET_MAX, RET_MAX, PS_NONE, 1'b1, VMAX, 1'b1);
      row(1'b0, RET_DOWN, RET_DOWN, RET_DOWN, RET_DOWN, PS_NONE, 1'b0, '0, 1'b0);
      row(1'b0, '0, '0, '0, '0, PS_NONE, 1'b0, '0, 1'b0);            // rebalance clips
      // Zero weights, longest term; no start first so holdings carry over.
      row(1'b0, RET_MAX, '0, '0, '0, PS_EMPTY, 1'b0, '0, 1'b0);
      row(1'b1, RET_MAX, RET_MAX, '0, '0, PS_NONE, 1'b1, '0, 1'b0);
      // Term 5 for three periods, then lowered to 2 under a phase of 3.
      row(1'b1, 32'h0010_0000, 32'hFFF8_0000, '0, '0, PS_HALVES_LONG, 1'b0, '0, 1'b0);
      row(1'b0, 32'h0003_0000, 32'h0000_8000, '0, '0, PS_NONE, 1'b0, '0, 1'b0);
      row(1'b0, 32'hFFFD_0000, 32'h0005_0000, '0, '0, PS_NONE, 1'b0, '0, 1'b0);
      row(1'b0, 32'h0001_0000, 32'h0002_0000, '0, '0, PS_HALVES_SHORT, 1'b0, '0, 1'b0);
      row(1'b0, 32'h0000_4000, 32'hFFFF_C000, '0, '0, PS_NONE, 1'b0, '0, 1'b0);
      row(1'b0, 32'h0007_0000, RET_DOWN, '0, '0, PS_NONE, 1'b0, '0, 1'b0);
      // Odd weights, count above 4.
      row(1'b1, RET_MIN, RET_DOWN, RET_UP100, RET_MAX, PS_ODD, 1'b0, '0, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      foreach (script[k]) begin
         if (script[k].preset != PS_NONE) begin
            drain_results();
            program_csr(presets[script[k].preset]);
         end
         offer_word(script[k].word, script[k].typed, script[k].want);
      end

      // Random segments: new registers each time, starts now and then. Half the
      // segments open without a start so a lowered term meets a live phase.
      seg         = 0;
      random_done = 0;
      while (random_done < RANDOM_PERIODS) begin
         drain_results();
         program_csr(draw_settings());
         if (random_done >= RANDOM_PERIODS - CALM_PERIODS) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = draw_idle_pct();
            rsp_stall_pct = draw_idle_pct();
         end
         len = $urandom_range(20, 80);
         if (seg == PRESSURE_SEGMENT) begin
            // Receiver stops taking words while the sender keeps pushing back to back.
            req_gap_pct = 0;
            hold_ask++;
         end
         first_start = $urandom_range(0, 1);
         for (int i = 0; i < len; i++) begin
            wd.start = (i == 0 && first_start) || ($urandom_range(0, 11) == 0);
            for (int j = 0; j < FIELD_ASSETS; j++) wd.ret[j] = draw_return();
            offer_word(wd, 1'b0, '0);
            random_done++;
         end
         seg++;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      fault_count += pending_values.size();

      $display("Run covered %0d periods over %0d register settings: %0d reloads, %0d rebalances,",
               periods_sent, settings_used, starts_seen, rebalances);
      $display("%0d value words checked, %0d of them flagged saturated, %0d faults.",
               values_checked, sat_seen, fault_count);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: rebalanced_portfolio_value.f
rtl/rpv_pkg.sv
rtl/rpv_req_if.sv
rtl/rpv_rsp_if.sv
rtl/rpv_mac_unit.sv
rtl/rpv_phase_ctr.sv
rtl/rpv_ctrl.sv
rtl/rebalanced_portfolio_value.sv
dv/tb_rebalanced_portfolio_value.sv
